FILE: hdl/keyframe_request_retry_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef KEYFRAME_REQUEST_RETRY_CONTROLLER_ASSERT_SVH
`define KEYFRAME_REQUEST_RETRY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define KRRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("krrc assertion failed");

// Next-cycle implication, switched off while reset is high.
`define KRRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("krrc assertion failed");

// Next-cycle implication that also holds across reset.
`define KRRC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("krrc assertion failed");

`endif

FILE: hdl/krrc_pkg.sv
`timescale 1ns / 1ps
package krrc_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned ATTEMPT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_BEGIN    = 3'd0;
  localparam logic [OP_W-1:0] OP_REQUEST  = 3'd1;
  localparam logic [OP_W-1:0] OP_THROUGH  = 3'd2;
  localparam logic [OP_W-1:0] OP_POLL     = 3'd3;
  localparam logic [OP_W-1:0] OP_PROGRESS = 3'd4;

  localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ISSUE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EXHAUSTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 1'd1;

  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL     = 16'd1000;
  localparam logic [ATTEMPT_W-1:0]  RESET_MAX_ATTEMPTS = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] generation;
    logic [WORD_W-1:0] watermark;
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] sequence_req;
    logic              keyframe;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [ACT_W-1:0]  action;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: hdl/krrc_in_stage.sv
`timescale 1ns / 1ps
module krrc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  krrc_pkg::item_t item_in,
  input  logic            advance,
  output logic            item_valid,
  output krrc_pkg::item_t item
);
  import krrc_pkg::*;

  // A new request may enter whenever the held one moves on in the same cycle.
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

FILE: hdl/krrc_core.sv
`timescale 1ns / 1ps
module krrc_core (
  input  logic              clk,
  input  logic              rst,
  input  krrc_pkg::cfg_wr_t cfg,
  input  krrc_pkg::item_t   item,
  input  logic              fire,
  output krrc_pkg::result_t result
);
  import krrc_pkg::*;

  logic [INTERVAL_W-1:0] retry_interval_ms;
  logic [ATTEMPT_W-1:0]  max_attempts;

  logic [WORD_W-1:0]    current_generation, current_generation_next;
  logic [WORD_W-1:0]    requested_count, requested_count_next;
  logic [WORD_W-1:0]    acknowledged_count, acknowledged_count_next;
  logic [WORD_W-1:0]    issued_count, issued_count_next;
  logic [WORD_W-1:0]    issued_after_seq, issued_after_seq_next;
  logic [WORD_W-1:0]    last_poll_time, last_poll_time_next;
  logic                 last_poll_valid, last_poll_valid_next;
  logic [WORD_W-1:0]    last_request_time, last_request_time_next;
  logic                 last_request_valid, last_request_valid_next;
  logic [ATTEMPT_W-1:0] attempt_count, attempt_count_next;

  logic [WORD_W-1:0] elapsed;
  logic              gen_ok;
  logic              poll_backwards;
  logic              poll_held;

  assign elapsed = item.now_ms - last_request_time;
  assign gen_ok  = (item.generation != '0) && (item.generation == current_generation);
  assign poll_backwards = last_poll_valid && (item.now_ms < last_poll_time);
  // Held inside the retry interval, or while capture has shown no newer frame.
  assign poll_held = last_request_valid &&
                     ((elapsed < {{(WORD_W-INTERVAL_W){1'b0}}, retry_interval_ms}) ||
                      (item.sequence_req <= issued_after_seq));

  always_comb begin
    current_generation_next = current_generation;
    requested_count_next    = requested_count;
    acknowledged_count_next = acknowledged_count;
    issued_count_next       = issued_count;
    issued_after_seq_next   = issued_after_seq;
    last_poll_time_next     = last_poll_time;
    last_poll_valid_next    = last_poll_valid;
    last_request_time_next  = last_request_time;
    last_request_valid_next = last_request_valid;
    attempt_count_next      = attempt_count;
    result                  = '{accepted: 1'b0, action: ACT_NONE};

    case (item.operation)
      OP_BEGIN: begin
        current_generation_next = item.generation;
        requested_count_next    = {{(WORD_W-1){1'b0}}, (item.generation != '0)};
        acknowledged_count_next = '0;
        issued_count_next       = '0;
        issued_after_seq_next   = '0;
        last_poll_time_next     = '0;
        last_poll_valid_next    = 1'b0;
        last_request_time_next  = '0;
        last_request_valid_next = 1'b0;
        attempt_count_next      = '0;
        result.accepted         = 1'b1;
      end
      OP_REQUEST: begin
        if (gen_ok && (requested_count != '1)) begin
          requested_count_next = requested_count + 1'b1;
          result.accepted      = 1'b1;
        end
      end
      OP_THROUGH: begin
        if (gen_ok && (item.watermark >= requested_count)) begin
          requested_count_next = item.watermark;
          result.accepted      = 1'b1;
        end
      end
      OP_POLL: begin
        if (!poll_backwards) begin
          last_poll_time_next  = item.now_ms;
          last_poll_valid_next = 1'b1;
          if ((requested_count != acknowledged_count) && !poll_held) begin
            if (attempt_count >= max_attempts) begin
              result.action = ACT_EXHAUSTED;
            end else begin
              issued_count_next       = requested_count;
              issued_after_seq_next   = item.sequence_req;
              last_request_time_next  = item.now_ms;
              last_request_valid_next = 1'b1;
              attempt_count_next      = attempt_count + 1'b1;
              result.action           = ACT_ISSUE;
            end
          end
        end
      end
      OP_PROGRESS: begin
        if ((item.generation == current_generation) && item.keyframe &&
            last_request_valid && (item.sequence_req > issued_after_seq) &&
            (issued_count > acknowledged_count)) begin
          acknowledged_count_next = issued_count;
          attempt_count_next      = '0;
          result.accepted         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval_ms <= RESET_INTERVAL;
      max_attempts      <= RESET_MAX_ATTEMPTS;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_RETRY_INTERVAL: retry_interval_ms <= cfg.data;
        CFG_MAX_ATTEMPTS:   max_attempts      <= cfg.data[ATTEMPT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_generation <= '0;
      requested_count    <= '0;
      acknowledged_count <= '0;
      issued_count       <= '0;
      issued_after_seq   <= '0;
      last_poll_time     <= '0;
      last_poll_valid    <= 1'b0;
      last_request_time  <= '0;
      last_request_valid <= 1'b0;
      attempt_count      <= '0;
    end else if (fire) begin
      current_generation <= current_generation_next;
      requested_count    <= requested_count_next;
      acknowledged_count <= acknowledged_count_next;
      issued_count       <= issued_count_next;
      issued_after_seq   <= issued_after_seq_next;
      last_poll_time     <= last_poll_time_next;
      last_poll_valid    <= last_poll_valid_next;
      last_request_time  <= last_request_time_next;
      last_request_valid <= last_request_valid_next;
      attempt_count      <= attempt_count_next;
    end
  end

endmodule

FILE: hdl/krrc_out_stage.sv
`timescale 1ns / 1ps
module krrc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  krrc_pkg::result_t result_in,
  output logic              load_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output krrc_pkg::result_t result
);
  import krrc_pkg::*;

  // The register may be refilled in the cycle its request is taken.
  assign load_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      result <= result_in;
    end
  end

endmodule

FILE: hdl/keyframe_request_retry_controller.sv
`timescale 1ns / 1ps
// Channel   Handshake                     Payload
// input     in_valid / in_ready           operation generation watermark now_ms
//                                         sequence_req keyframe
// output    out_valid / out_ready         accepted action
// config    cfg_wr_en (no wait)           cfg_index cfg_data
//
// One request per cycle sustained while the output is not stalled; the result of a request is
// registered in the output register, with the state update and decision done in one pass between
// the input register and the output register.
// Reset is synchronous and restores the state and the configuration defaults.
// A stalled output holds its result while the input register still takes one
// further request.
module keyframe_request_retry_controller (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [krrc_pkg::OP_W-1:0]                 operation,
  input  logic [krrc_pkg::WORD_W-1:0]               generation,
  input  logic [krrc_pkg::WORD_W-1:0]               watermark,
  input  logic [krrc_pkg::WORD_W-1:0]               now_ms,
  input  logic [krrc_pkg::WORD_W-1:0]               sequence_req,
  input  logic                                      keyframe,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      accepted,
  output logic [krrc_pkg::ACT_W-1:0]                action,
  input  logic                                      cfg_wr_en,
  input  logic [krrc_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [krrc_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import krrc_pkg::*;

  item_t   item_in;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    load_ok;
  cfg_wr_t cfg;
  result_t core_result;
  result_t result;

  assign item_in = '{operation: operation, generation: generation, watermark: watermark,
                     now_ms: now_ms, sequence_req: sequence_req, keyframe: keyframe};
  assign cfg     = '{we: cfg_wr_en, index: cfg_index, data: cfg_data};
  assign advance = item_valid && load_ok;

  krrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  krrc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .fire   (advance),
    .result (core_result)
  );

  krrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result_in (core_result),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign accepted = result.accepted;
  assign action   = result.action;

endmodule

FILE: hdl/krrc_checker.sv
`timescale 1ns / 1ps
`include "keyframe_request_retry_controller_assert.svh"
module krrc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              accepted,
  input  logic [krrc_pkg::ACT_W-1:0]        action
);
  import krrc_pkg::*;

  // A poll decision and an acceptance never come from the same request.
  `KRRC_ASSERT_IMPLY(a_acc_excl_action, clk, rst, out_valid, !(accepted && (action != ACT_NONE)))
  `KRRC_ASSERT_IMPLY(a_action_legal, clk, rst, out_valid, action <= ACT_EXHAUSTED)
  // With the output empty nothing can block the input side.
  `KRRC_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `KRRC_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(accepted) && $stable(action))
  `KRRC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind keyframe_request_retry_controller krrc_checker u_krrc_checker (.*);
